// ===== hdl/bank_mapper_with_irq_counter_assert.svh =====
// Assertion helpers included by the top-level RTL module.
`ifndef BANK_MAPPER_WITH_IRQ_COUNTER_ASSERT_SVH
`define BANK_MAPPER_WITH_IRQ_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define BM19_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bm19 assertion failed");

// Next-cycle implication.
`define BM19_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bm19 assertion failed");

`endif

// ===== hdl/bm19_pkg.sv =====
package bm19_pkg;

  typedef enum logic [1:0] {
    MODE_CPU_WRITE = 2'd0,
    MODE_CPU_READ  = 2'd1,
    MODE_PPU_READ  = 2'd2,
    MODE_TICK      = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } item_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_hit;
    logic [7:0] rom_page;
    logic       use_internal_ram;
    logic       internal_page;
    logic       wram_writable;
    logic       irq;
  } item_out_t;

  localparam logic [14:0] IRQ_LIMIT       = 15'h7FFF;
  localparam logic [7:0]  INTERNAL_SEL    = 8'hE0;
  localparam logic [7:0]  PRG_MASK        = 8'h3F;
  localparam logic [7:0]  PROTECT_HIGH    = 8'hF0;
  localparam logic [7:0]  PROTECT_UNLOCK  = 8'h40;
  localparam logic [7:0]  FIXED_PRG_BANK  = 8'hFF;
  localparam logic [7:0]  CHR_MASK_RESET  = 8'hFF;
  localparam logic [7:0]  PROTECT_RESET   = 8'hFF;
  localparam logic [7:0]  PRG_RESET_BASE  = 8'hFC;
  localparam logic [7:0]  NT_RESET_BASE   = 8'hE0;

endpackage

// ===== hdl/bank_mapper_with_irq_counter.sv =====
// Cartridge bank controller with a cycle-driven IRQ counter.
// Input channel (in_valid/in_ready/in_item): one bus event per transfer:
//   CPU write, CPU read or address lookup, PPU lookup, or an
//   IRQ counter tick. Output channel (out_valid/out_ready/out_item): one
//   result per input, in order, with the IRQ level after that event.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes the nametable
//   ROM page mask; always ready, write only while the block is idle.
// Path: the input register, then decode and state update into the result
//   register.
// Throughput: one item per cycle unless stalled by out_ready; the decode and
//   the 15-bit counter add sit in a single stage between the two registers.
// Stall: while out_ready is low the result is held; one more item waits
//   in the input register, after which in_ready drops.
// Reset (rst, synchronous): clears both stages and restores the bank,
//   protect, mask and counter registers to their power-on values.
module bank_mapper_with_irq_counter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bm19_pkg::item_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bm19_pkg::item_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import bm19_pkg::*;

  `include "bank_mapper_with_irq_counter_assert.svh"

  item_in_t  in_q;
  logic      in_q_valid;
  logic      advance;
  logic      chr_bank_mask;
  logic [7:0] chr_mask;
  item_out_t result;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;
  assign chr_bank_mask = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_mask <= CHR_MASK_RESET;
    end else if (chr_bank_mask) begin
      chr_mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  bm19_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .item          (in_q),
    .chr_bank_mask (chr_mask),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  `BM19_ASSERT_NEXT(a_advance_fills_out, advance, out_valid)
  `BM19_ASSERT_NEXT(a_held_item_kept, in_q_valid && out_valid && !out_ready, in_q_valid)
  `BM19_ASSERT_NOW(a_empty_stage_ready, !in_q_valid, in_ready)

endmodule

// ===== hdl/bm19_core.sv =====
module bm19_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  bm19_pkg::item_in_t  item,
  input  logic [7:0]          chr_bank_mask,
  output bm19_pkg::item_out_t result
);
  import bm19_pkg::*;

  logic [7:0]  pattern_banks [8];
  logic [7:0]  nametable_banks [4];
  logic [7:0]  program_banks [3];
  logic [7:0]  protect_byte;
  logic [14:0] irq_counter;
  logic        irq_enabled;
  logic        irq_pending;

  logic [14:0] irq_counter_next;
  logic        irq_enabled_next;
  logic        irq_pending_next;
  logic [15:0] tick_sum;
  logic [15:0] a;
  logic [7:0]  prg_sel;
  logic [7:0]  pat_val;
  logic [7:0]  nt_val;
  logic [7:0]  wram_mask;
  logic        force_rom;

  assign a        = item.address;
  assign tick_sum = {1'b0, irq_counter} + {8'b0, item.cycles};
  assign pat_val  = pattern_banks[a[12:10]];
  assign nt_val   = nametable_banks[a[11:10]];
  assign force_rom = a[12] ? program_banks[1][7] : program_banks[1][6];
  assign prg_sel  = (a[14:13] == 2'd3) ? FIXED_PRG_BANK : program_banks[a[14:13]];
  assign wram_mask = PROTECT_HIGH | (8'd1 << a[12:11]);

  always_comb begin
    result           = '0;
    irq_counter_next = irq_counter;
    irq_enabled_next = irq_enabled;
    irq_pending_next = irq_pending;
    case (item.mode)
      MODE_CPU_WRITE: begin
        if (a[15:12] == 4'h5) begin
          irq_pending_next = 1'b0;
          if (a[11]) begin
            irq_counter_next = {item.data[6:0], irq_counter[7:0]};
            irq_enabled_next = item.data[7];
          end else begin
            irq_counter_next = {irq_counter[14:8], item.data};
          end
        end
      end
      MODE_CPU_READ: begin
        if (a[15:12] == 4'h5) begin
          result.read_data = a[11] ? {1'b0, irq_counter[14:8]} : irq_counter[7:0];
          result.read_hit  = 1'b1;
        end else if (a[15:13] == 3'b011) begin
          result.wram_writable = ((protect_byte & wram_mask) == PROTECT_UNLOCK);
        end else if (a[15]) begin
          result.rom_page = prg_sel & PRG_MASK;
        end
      end
      MODE_PPU_READ: begin
        if (!a[13]) begin
          if (force_rom || pat_val < INTERNAL_SEL) begin
            result.rom_page = pat_val;
          end else begin
            result.use_internal_ram = 1'b1;
            result.internal_page    = pat_val[0];
          end
        end else begin
          if (nt_val < INTERNAL_SEL) begin
            result.rom_page = nt_val & chr_bank_mask;
          end else begin
            result.use_internal_ram = 1'b1;
            result.internal_page    = nt_val[0];
          end
        end
      end
      MODE_TICK: begin
        if (irq_enabled) begin
          if (tick_sum >= {1'b0, IRQ_LIMIT}) begin
            irq_counter_next = IRQ_LIMIT;
            irq_pending_next = 1'b1;
          end else begin
            irq_counter_next = tick_sum[14:0];
          end
        end
      end
      default: begin
      end
    endcase
    result.irq = irq_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) pattern_banks[i] <= 8'(i);
      for (int i = 0; i < 4; i++) nametable_banks[i] <= NT_RESET_BASE | 8'(i % 2);
      for (int i = 0; i < 3; i++) program_banks[i] <= PRG_RESET_BASE + 8'(i);
      protect_byte <= PROTECT_RESET;
      irq_counter  <= '0;
      irq_enabled  <= 1'b0;
      irq_pending  <= 1'b0;
    end else if (fire) begin
      irq_counter <= irq_counter_next;
      irq_enabled <= irq_enabled_next;
      irq_pending <= irq_pending_next;
      if (item.mode == MODE_CPU_WRITE) begin
        if (a[15:14] == 2'b10) begin
          pattern_banks[a[13:11]] <= item.data;
        end else if (a[15:13] == 3'b110) begin
          nametable_banks[a[12:11]] <= item.data;
        end else if (a[15:13] == 3'b111) begin
          if (a[12:11] == 2'd3) begin
            protect_byte <= item.data;
          end else begin
            program_banks[a[12:11]] <= item.data;
          end
        end
      end
    end
  end

endmodule

// ===== test/bank_mapper_with_irq_counter_tb.sv =====
`timescale 1ns / 1ps
module bank_mapper_with_irq_counter_tb;
  import bm19_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  item_in_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  item_out_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  bit        idle_on = 1'b1;
  bit        hold_output = 1'b0;
  int        error_count = 0;
  int        quiet_cycles = 0;
  item_out_t pending_results[$];

  logic [7:0]  prg_bank [4];
  logic [7:0]  chr_bank [8];
  logic [7:0]  nt_bank [4];
  logic [7:0]  protect_bits;
  logic [7:0]  nt_mask;
  logic [14:0] irq_count;
  logic        irq_en;
  logic        irq_pend;

  always #5 clk = ~clk;

  bank_mapper_with_irq_counter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  task automatic reset_bank_model();
    for (int i = 0; i < 4; i++) begin
      prg_bank[i] = PRG_RESET_BASE + 8'(i);
      nt_bank[i]  = NT_RESET_BASE + 8'(i % 2);
    end
    for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
    protect_bits = PROTECT_RESET;
    nt_mask      = CHR_MASK_RESET;
    irq_count    = '0;
    irq_en       = 1'b0;
    irq_pend     = 1'b0;
  endtask

  // Applies one bus event to the predicted state and returns its result.
  function automatic item_out_t map_bus_event(item_in_t ev);
    item_out_t   res;
    logic [15:0] a;
    logic [7:0]  v;
    logic [15:0] sum;
    logic        force_rom;
    res = '0;
    a = ev.address;
    case (ev.mode)
      MODE_CPU_WRITE: begin
        if (a >= 16'h5000 && a <= 16'h5FFF) begin
          irq_pend = 1'b0;
          if (a[11]) begin
            irq_count[14:8] = ev.data[6:0];
            irq_en = ev.data[7];
          end else begin
            irq_count[7:0] = ev.data;
          end
        end else if (a >= 16'h8000 && a <= 16'hBFFF) begin
          chr_bank[a[13:11]] = ev.data;
        end else if (a >= 16'hC000 && a <= 16'hDFFF) begin
          nt_bank[a[12:11]] = ev.data;
        end else if (a >= 16'hE000 && a <= 16'hF7FF) begin
          prg_bank[a[12:11]] = ev.data;
        end else if (a >= 16'hF800) begin
          protect_bits = ev.data;
        end
      end
      MODE_CPU_READ: begin
        if (a >= 16'h5000 && a <= 16'h5FFF) begin
          res.read_data = a[11] ? {1'b0, irq_count[14:8]} : irq_count[7:0];
          res.read_hit  = 1'b1;
        end else if (a >= 16'h6000 && a <= 16'h7FFF) begin
          res.wram_writable =
            (protect_bits & (PROTECT_HIGH | (8'd1 << a[12:11]))) == PROTECT_UNLOCK;
        end else if (a >= 16'h8000) begin
          res.rom_page = prg_bank[a[14:13]] & PRG_MASK;
        end
      end
      MODE_PPU_READ: begin
        if (!a[13]) begin
          v = chr_bank[a[12:10]];
          // slots 4-7 are forced by bit 7 only
          force_rom = a[12] ? prg_bank[1][7] : prg_bank[1][6];
          if (force_rom || v < INTERNAL_SEL) begin
            res.rom_page = v;
          end else begin
            res.use_internal_ram = 1'b1;
            res.internal_page = v[0];
          end
        end else begin
          v = nt_bank[a[11:10]];
          if (v < INTERNAL_SEL) begin
            res.rom_page = v & nt_mask;
          end else begin
            res.use_internal_ram = 1'b1;
            res.internal_page = v[0];
          end
        end
      end
      MODE_TICK: begin
        if (irq_en) begin
          sum = {1'b0, irq_count} + {8'b0, ev.cycles};
          if (sum >= {1'b0, IRQ_LIMIT}) begin
            irq_count = IRQ_LIMIT;
            irq_pend = 1'b1;
          end else begin
            irq_count = sum[14:0];
          end
        end
      end
      default: begin
      end
    endcase
    res.irq = irq_pend;
    return res;
  endfunction

  task automatic send_event(mode_t m, logic [15:0] a, logic [7:0] d, logic [7:0] c);
    item_in_t ev;
    ev.mode    = m;
    ev.address = a;
    ev.data    = d;
    ev.cycles  = c;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_item  <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(map_bus_event(ev));
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_nametable_mask(logic [7:0] value);
    wait_until_idle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    nt_mask = value;
  endtask

  task automatic send_random_event();
    mode_t       m;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  c;
    m = mode_t'(2'($urandom_range(0, 3)));
    a = 16'($urandom);
    d = 8'($urandom);
    c = 8'($urandom);
    case (m)
      MODE_CPU_WRITE, MODE_CPU_READ: begin
        case ($urandom_range(0, 7))
          0, 1: a = {4'h5, a[11:0]};
          2: a = {3'b011, a[12:0]};
          3, 4, 5: a[15] = 1'b1;
          default: ;
        endcase
        // push the counter near saturation, banks toward internal RAM
        if (a[15:12] == 4'h5 && a[11] && $urandom_range(0, 1) == 1) begin
          d = 8'($urandom_range(8'hFC, 8'hFF));
        end else if (a >= 16'hF800 && $urandom_range(0, 1) == 1) begin
          d = {4'h4, d[3:0]};
        end else if ($urandom_range(0, 3) == 0) begin
          d = {3'b111, d[4:0]};
        end
      end
      MODE_TICK: begin
        case ($urandom_range(0, 5))
          0: c = 8'h00;
          1: c = 8'hFF;
          default: ;
        endcase
      end
      default: ;
    endcase
    send_event(m, a, d, c);
  endtask

  task automatic test_power_on_lookups();
    send_event(MODE_PPU_READ, 16'h0000, 8'h00, 8'h00);
    send_event(MODE_PPU_READ, 16'hEC00, 8'hFF, 8'hFF);
    send_event(MODE_CPU_READ, 16'hFFFF, 8'h00, 8'h00);
    send_event(MODE_CPU_READ, 16'h6000, 8'h00, 8'h00);
    send_event(MODE_CPU_READ, 16'h5800, 8'h00, 8'h00);
    send_event(MODE_TICK, 16'h0000, 8'h00, 8'hFF);
    wait_until_idle();
  endtask

  task automatic test_bank_registers();
    send_event(MODE_CPU_WRITE, 16'h8000, 8'hE5, 8'h00);
    send_event(MODE_CPU_WRITE, 16'hE800, 8'h40, 8'h00);
    send_event(MODE_PPU_READ, 16'h0000, 8'h00, 8'h00);
    // bit 6 alone must not force the upper slots
    send_event(MODE_CPU_WRITE, 16'hB800, 8'hFF, 8'h00);
    send_event(MODE_PPU_READ, 16'h1FFF, 8'h00, 8'h00);
    send_event(MODE_CPU_WRITE, 16'hF800, 8'h40, 8'h00);
    send_event(MODE_CPU_READ, 16'h7800, 8'h00, 8'h00);
    send_event(MODE_CPU_WRITE, 16'h0000, 8'hFF, 8'h00);
    send_event(MODE_CPU_READ, 16'h4000, 8'h00, 8'h00);
    wait_until_idle();
  endtask

  task automatic test_irq_counter();
    send_event(MODE_CPU_WRITE, 16'h5000, 8'hF0, 8'h00);
    send_event(MODE_CPU_WRITE, 16'h5800, 8'hFF, 8'h00);
    send_event(MODE_TICK, 16'h0000, 8'h00, 8'h00);
    send_event(MODE_TICK, 16'h0000, 8'h00, 8'h0F);
    send_event(MODE_CPU_READ, 16'h5FFF, 8'h00, 8'h00);
    // write clears the IRQ, then a zero-cycle tick at the limit raises it
    send_event(MODE_CPU_WRITE, 16'h5800, 8'hFF, 8'h00);
    send_event(MODE_TICK, 16'h0000, 8'h00, 8'h00);
    wait_until_idle();
  endtask

  task automatic test_nametable_mask();
    send_event(MODE_CPU_WRITE, 16'hC000, 8'hA5, 8'h00);
    set_nametable_mask(8'h0F);
    send_event(MODE_PPU_READ, 16'h3000, 8'h00, 8'h00);
    set_nametable_mask(8'h00);
    send_event(MODE_PPU_READ, 16'h2000, 8'h00, 8'h00);
    wait_until_idle();
  endtask

  task automatic test_random_traffic(int count, logic [7:0] mask);
    set_nametable_mask(mask);
    repeat (count) send_random_event();
    wait_until_idle();
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_output = 1'b1;
    repeat (24) send_random_event();
    wait_until_idle();
    idle_on = 1'b1;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    item_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %p", $time, out_item);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, out_item.read_data);
        check_field("read_hit", {7'b0, want.read_hit}, {7'b0, out_item.read_hit});
        check_field("rom_page", want.rom_page, out_item.rom_page);
        check_field("use_internal_ram", {7'b0, want.use_internal_ram},
                    {7'b0, out_item.use_internal_ram});
        check_field("internal_page", {7'b0, want.internal_page},
                    {7'b0, out_item.internal_page});
        check_field("wram_writable", {7'b0, want.wram_writable},
                    {7'b0, out_item.wram_writable});
        check_field("irq", {7'b0, want.irq}, {7'b0, out_item.irq});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    reset_bank_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_nametable_mask(CHR_MASK_RESET);
    test_power_on_lookups();
    test_bank_registers();
    test_irq_counter();
    test_nametable_mask();
    test_random_traffic(200, 8'h00);
    test_random_traffic(200, 8'($urandom));
    test_random_traffic(150, 8'hFF);
    test_output_backpressure();
    idle_on = 1'b0;
    test_random_traffic(200, 8'($urandom));
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bm19_pkg.sv
hdl/bm19_core.sv
hdl/bank_mapper_with_irq_counter.sv
test/bank_mapper_with_irq_counter_tb.sv
